// ----- hdl/mci_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mci_pkg;

	// Field widths
	localparam int CMD_W    = 3;
	localparam int CH_W     = 4;
	localparam int PER_W    = 32;
	localparam int TIME_W   = 32;

	// Slots reachable through the channel field
	localparam int MAX_SLOTS = 1 << CH_W;

	// Stream word layout
	localparam int S_DATA_W = 72;
	localparam int S_USER_W = CMD_W;
	localparam int M_DATA_W = 8;
	localparam int M_USER_W = 1;

	localparam int CH_LO    = 0;
	localparam int PER_LO   = CH_LO + CH_W;
	localparam int ONCE_BIT = PER_LO + PER_W;
	localparam int NOW_LO   = ONCE_BIT + 1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_PERIOD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

	// Slot table write request
	typedef struct packed {
		logic              en;
		logic              set_active;
		logic              clr_active;
		logic              wr_period;
		logic              wr_stamp;
		logic              wr_once;
		logic              once;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] stamp;
	} tbl_wr_t;

	// Slot table read data
	typedef struct packed {
		logic              active;
		logic              once;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] stamp;
	} tbl_rd_t;

endpackage

`default_nettype wire

// ----- hdl/mci_tbl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mci_tbl #(
	parameter int SLOTS = 16,
	parameter int SW    = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	input  mci_pkg::tbl_wr_t   wr,
	input  wire [SW-1:0]       wr_addr,
	input  wire [SW-1:0]       rd_addr,
	output mci_pkg::tbl_rd_t   rd
);
	import mci_pkg::*;

	logic              active_q [SLOTS];
	logic              once_q   [SLOTS];
	logic [PER_W-1:0]  period_q [SLOTS];
	logic [TIME_W-1:0] stamp_q  [SLOTS];

	// Only the active bits need reset: an inactive slot never fires, and add
	// rewrites every field before the slot can fire again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				active_q[i] <= 1'b0;
			end
		end else if (wr.en) begin
			if (wr.clr_active) begin
				active_q[wr_addr] <= 1'b0;
			end else if (wr.set_active) begin
				active_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.wr_once) begin
				once_q[wr_addr] <= wr.once;
			end
			if (wr.wr_period) begin
				period_q[wr_addr] <= wr.period;
			end
			if (wr.wr_stamp) begin
				stamp_q[wr_addr] <= wr.stamp;
			end
		end
	end

	assign rd.active = active_q[rd_addr];
	assign rd.once   = once_q[rd_addr];
	assign rd.period = period_q[rd_addr];
	assign rd.stamp  = stamp_q[rd_addr];

endmodule

`default_nettype wire

// ----- hdl/mci_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mci_cmp (
	input  wire [mci_pkg::TIME_W-1:0] now,
	input  mci_pkg::tbl_rd_t          rd,
	output logic                      hit
);
	import mci_pkg::*;

	logic [TIME_W-1:0] elapsed;

	// Wrapping elapsed time, then a strict compare against the period
	assign elapsed = now - rd.stamp;
	assign hit     = rd.active && (rd.period != '0) && (elapsed > rd.period);

endmodule

`default_nettype wire

// ----- hdl/mci_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mci_seq #(
	parameter int SLOTS = 16,
	parameter int SW    = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [mci_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire [mci_pkg::S_USER_W-1:0]  s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [mci_pkg::M_DATA_W-1:0] m_tdata,
	output logic [mci_pkg::M_USER_W-1:0] m_tuser,
	output logic                         m_tlast,
	output mci_pkg::tbl_wr_t             tbl_wr,
	output logic [SW-1:0]                wr_addr,
	output logic [SW-1:0]                rd_addr,
	input  mci_pkg::tbl_rd_t             tbl_rd,
	input  wire                          hit,
	output logic [mci_pkg::TIME_W-1:0]   now
);
	import mci_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CH_W-1:0]   ch_q;
	logic [PER_W-1:0]  per_q;
	logic              once_q;
	logic [TIME_W-1:0] now_q;
	logic [SW-1:0]     idx_q;
	logic              pend_vld_q;
	logic [SW-1:0]     pend_idx_q;
	logic              out_vld_q;
	logic              out_fired_q;
	logic [CH_W-1:0]   out_ch_q;
	logic              out_last_q;

	logic can_push;
	logic scan_stall;
	logic scan_end;
	logic in_range;
	logic out_push;

	assign can_push   = !out_vld_q || m_tready;
	// A second hit needs the output slot for the one held back
	assign scan_stall = (state_q == ST_SCAN) && hit && pend_vld_q && !can_push;
	assign scan_end   = (idx_q == SW'(SLOTS - 1));
	assign in_range   = (int'(ch_q) < SLOTS);
	// Load the output register with a released hit or the closing word
	assign out_push   = ((state_q == ST_SCAN) && hit && pend_vld_q && can_push) ||
		((state_q == ST_FLUSH) && can_push);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(M_DATA_W - CH_W){1'b0}}, out_ch_q};
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;
	assign rd_addr  = idx_q;
	assign now      = now_q;

	always_comb begin
		tbl_wr        = '0;
		tbl_wr.period = per_q;
		tbl_wr.stamp  = now_q;
		tbl_wr.once   = once_q;
		wr_addr       = idx_q;
		unique case (state_q)
			ST_APPLY: begin
				wr_addr   = ch_q[SW-1:0];
				tbl_wr.en = in_range;
				unique case (cmd_q)
					CMD_ADD: begin
						tbl_wr.set_active = 1'b1;
						tbl_wr.wr_period  = 1'b1;
						tbl_wr.wr_stamp   = 1'b1;
						tbl_wr.wr_once    = 1'b1;
					end
					CMD_SET_PERIOD: begin
						tbl_wr.wr_period = 1'b1;
						tbl_wr.wr_stamp  = 1'b1;
					end
					CMD_RESTART: begin
						tbl_wr.wr_stamp = 1'b1;
					end
					CMD_REMOVE: begin
						tbl_wr.clr_active = 1'b1;
					end
					default: begin
						tbl_wr.en = 1'b0;
					end
				endcase
			end
			ST_SCAN: begin
				// Restamp the firing slot, disarm it if one-shot
				tbl_wr.en         = hit && !scan_stall;
				tbl_wr.wr_stamp   = 1'b1;
				tbl_wr.clr_active = tbl_rd.once;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_TICK;
			ch_q        <= '0;
			per_q       <= '0;
			once_q      <= 1'b0;
			now_q       <= '0;
			idx_q       <= '0;
			pend_vld_q  <= 1'b0;
			pend_idx_q  <= '0;
			out_vld_q   <= 1'b0;
			out_fired_q <= 1'b0;
			out_ch_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_push) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q      <= s_tuser;
						ch_q       <= s_tdata[CH_LO +: CH_W];
						per_q      <= s_tdata[PER_LO +: PER_W];
						once_q     <= s_tdata[ONCE_BIT];
						now_q      <= s_tdata[NOW_LO +: TIME_W];
						idx_q      <= '0;
						pend_vld_q <= 1'b0;
						state_q    <= (s_tuser == CMD_TICK) ? ST_SCAN : ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_FLUSH;
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (hit) begin
							// Release the held hit; the newest one waits to learn if it is last
							if (pend_vld_q) begin
								out_fired_q <= 1'b1;
								out_ch_q    <= CH_W'(pend_idx_q);
								out_last_q  <= 1'b0;
							end
							pend_vld_q <= 1'b1;
							pend_idx_q <= idx_q;
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (can_push) begin
						out_fired_q <= pend_vld_q;
						out_ch_q    <= pend_vld_q ? CH_W'(pend_idx_q) : '0;
						out_last_q  <= 1'b1;
						pend_vld_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/multi_channel_interval_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                              tuser    tlast
// s_*       in   channel[3:0], period[35:4], one_shot[36],       cmd      -
//                now[68:37], zero[71:69]
// m_*       out  fired_channel[3:0], zero[7:4]                   fired    last
//
// A tick scans the slots, one per cycle unless the scan stalls, and flushes before
// ready returns; SLOTS = min(CHANNELS, 16) slots share one elapsed-time comparator.
// Add, set period, restart, remove and unused codes go through apply, then flush.
// Asynchronous reset disarms every slot at once; no clearing pass follows.
// A stalled output holds its word and the closing word waits for it; a scan
// pauses only when a further slot fires while the previous hit still waits.

module multi_channel_interval_timer #(
	parameter int CHANNELS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// channel, period, one_shot, now, zero pad
	input  wire [mci_pkg::S_DATA_W-1:0]  s_tdata,
	// cmd
	input  wire [mci_pkg::S_USER_W-1:0]  s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// fired_channel, zero pad
	output logic [mci_pkg::M_DATA_W-1:0] m_tdata,
	// fired
	output logic [mci_pkg::M_USER_W-1:0] m_tuser,
	output logic                         m_tlast
);
	import mci_pkg::*;

	// Slots above what the channel field can address never arm, so leave them out
	localparam int SLOTS = (CHANNELS < MAX_SLOTS) ? CHANNELS : MAX_SLOTS;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	tbl_wr_t           tbl_wr;
	tbl_rd_t           tbl_rd;
	logic [SW-1:0]     wr_addr;
	logic [SW-1:0]     rd_addr;
	logic              hit;
	logic [TIME_W-1:0] now;

	// Command sequencer, slot scan and output staging
	mci_seq #(
		.SLOTS (SLOTS),
		.SW    (SW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.tbl_wr   (tbl_wr),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.tbl_rd   (tbl_rd),
		.hit      (hit),
		.now      (now)
	);

	// Slot state: one write port, one read port at the scan index
	mci_tbl #(
		.SLOTS (SLOTS),
		.SW    (SW)
	) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd      (tbl_rd)
	);

	// Shared expiry comparator
	mci_cmp u_cmp (
		.now (now),
		.rd  (tbl_rd),
		.hit (hit)
	);

endmodule

`default_nettype wire

// ----- hdl/mci_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mci_chk (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tvalid,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [mci_pkg::M_DATA_W-1:0]  m_tdata,
	input wire [mci_pkg::M_USER_W-1:0]  m_tuser,
	input wire                          m_tlast
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// A word without a fired slot closes its command and carries channel zero
	a_idle_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("idle word not final or nonzero channel");

	// Busy after taking a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accepting a command");

	// Once ready again, any word still waiting ends the previous command
	a_ready_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("ready while results of a command are still pending");

endmodule

bind multi_channel_interval_timer mci_chk u_chk (.*);

`default_nettype wire

// ----- sim/timer_expiry_checker.sv -----
`timescale 1ns / 1ps

module timer_expiry_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	input  wire                         s_tready,
	// channel, period, one_shot, now, zero pad
	input  wire [mci_pkg::S_DATA_W-1:0] s_tdata,
	// cmd
	input  wire [mci_pkg::S_USER_W-1:0] s_tuser,
	input  wire                         m_tvalid,
	input  wire                         m_tready,
	// fired_channel, zero pad
	input  wire [mci_pkg::M_DATA_W-1:0] m_tdata,
	// fired
	input  wire [mci_pkg::M_USER_W-1:0] m_tuser,
	input  wire                         m_tlast,
	output int                          mismatches,
	output int                          pending
);
	import mci_pkg::*;

	typedef struct packed {
		logic            fired;
		logic [CH_W-1:0] slot;
		logic            last;
	} expiry_t;

	logic              armed       [MAX_SLOTS];
	logic              single_shot [MAX_SLOTS];
	logic [PER_W-1:0]  interval    [MAX_SLOTS];
	logic [TIME_W-1:0] started_at  [MAX_SLOTS];
	expiry_t           expiry_q[$];
	expiry_t           want;

	task automatic report_mismatch(input string what);
		if (mismatches < 100) begin
			$display("%0t ns: %s", $time, what);
		end
		mismatches++;
	endtask

	// Apply one command to the slot table and queue the words it must produce.
	task automatic advance_table(input logic [CMD_W-1:0] op, input logic [CH_W-1:0] ch,
			input logic [PER_W-1:0] per, input logic once, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0]    elapsed;
		logic [MAX_SLOTS-1:0] due;
		int                   newest;
		int                   i;
		expiry_t              e;
		due = '0;
		newest = -1;
		case (op)
			CMD_TICK: begin
				for (i = 0; i < MAX_SLOTS; i++) begin
					elapsed = now - started_at[i];
					if (armed[i] && interval[i] != '0 && elapsed > interval[i]) begin
						due[i] = 1'b1;
						newest = i;
						started_at[i] = now;
						if (single_shot[i]) begin
							armed[i] = 1'b0;
						end
					end
				end
			end
			CMD_ADD: begin
				armed[ch] = 1'b1;
				interval[ch] = per;
				started_at[ch] = now;
				single_shot[ch] = once;
			end
			CMD_SET_PERIOD: begin
				interval[ch] = per;
				started_at[ch] = now;
			end
			CMD_RESTART: begin
				started_at[ch] = now;
			end
			CMD_REMOVE: begin
				armed[ch] = 1'b0;
			end
			default: ;
		endcase
		for (i = 0; i < MAX_SLOTS; i++) begin
			if (due[i]) begin
				e.fired = 1'b1;
				e.slot = i[CH_W-1:0];
				e.last = (i == newest);
				expiry_q = {expiry_q, e};
			end
		end
		// nothing expired: one idle word closes the command
		if (newest < 0) begin
			e.fired = 1'b0;
			e.slot = '0;
			e.last = 1'b1;
			expiry_q = {expiry_q, e};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (armed[k]) begin
				armed[k] = 1'b0;
				single_shot[k] = 1'b0;
				interval[k] = '0;
				started_at[k] = '0;
			end
			expiry_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expiry_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word fired=%0b channel=%0d last=%0b",
						m_tuser[0], m_tdata[CH_W-1:0], m_tlast));
				end else begin
					want = expiry_q.pop_front();
					if (m_tuser[0] !== want.fired) begin
						report_mismatch($sformatf("fired %0b, expected %0b",
							m_tuser[0], want.fired));
					end
					if (m_tdata[CH_W-1:0] !== want.slot) begin
						report_mismatch($sformatf("fired_channel %0d, expected %0d",
							m_tdata[CH_W-1:0], want.slot));
					end
					if (m_tdata[M_DATA_W-1:CH_W] !== '0) begin
						report_mismatch($sformatf("tdata pad %0h not zero",
							m_tdata[M_DATA_W-1:CH_W]));
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b",
							m_tlast, want.last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				advance_table(s_tuser, s_tdata[CH_LO +: CH_W], s_tdata[PER_LO +: PER_W],
					s_tdata[ONCE_BIT], s_tdata[NOW_LO +: TIME_W]);
			end
			pending <= expiry_q.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import mci_pkg::*;

	// Worst run: ~250 commands, each up to 16 words held behind a stalled
	// receiver, plus the scan and sender gaps; this is several times that.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 220;
	// A tick scans 16 slots plus overhead; give the tail room for stalls.
	localparam int DRAIN_CYCLES = 64;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	// channel, period, one_shot, now, zero pad
	logic [S_DATA_W-1:0] s_tdata = '0;
	// cmd
	logic [S_USER_W-1:0] s_tuser = CMD_TICK;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	// fired_channel, zero pad
	wire  [M_DATA_W-1:0] m_tdata;
	// fired
	wire  [M_USER_W-1:0] m_tuser;
	wire                 m_tlast;
	int                  mismatches;
	int                  pending;
	int                  cycles = 0;
	int                  burst_left = 0;
	int                  counted = 0;
	int                  ready_run = 0;
	int                  ready_mode = 0;
	logic [TIME_W-1:0]   t_now = '0;

	multi_channel_interval_timer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	timer_expiry_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: hold one stall mode for a random stretch, then pick another.
	// Modes: always ready, coin flip, mostly stalled, strict alternation.
	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_run <= $urandom_range(4, 40);
		end else begin
			ready_run <= ready_run - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ~m_tready;
		endcase
	end

	// Offer one command word and wait for its handshake. Keep tvalid high
	// inside a burst; at a burst end drop it for a random gap (or none).
	task automatic send_word(input logic [CMD_W-1:0] op, input logic [CH_W-1:0] ch,
			input logic [PER_W-1:0] per, input logic once, input logic [TIME_W-1:0] at);
		logic [S_DATA_W-1:0] word;
		int                  gap;
		word = '0;
		word[CH_LO +: CH_W] = ch;
		word[PER_LO +: PER_W] = per;
		word[ONCE_BIT] = once;
		word[NOW_LO +: TIME_W] = at;
		s_tdata <= word;
		s_tuser <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		counted++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Mostly short periods so slots expire often; sometimes zero (never
	// fires), all ones (never exceeded) or a full random value.
	function automatic logic [PER_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: pick_period = '0;
			1: pick_period = '1;
			2: pick_period = $urandom();
			default: pick_period = $urandom_range(1, 12);
		endcase
	endfunction

	initial begin
		int k;
		int steps;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, commands on idle slots, zero and maximum
		// periods, one-shot disarm, re-add of an armed slot, unused codes,
		// and expiry across the 32-bit wrap of the time count.
		send_word(CMD_TICK, '0, '0, 1'b0, '0);
		send_word(CMD_REMOVE, 4'd3, '0, 1'b0, '0);
		send_word(CMD_SET_PERIOD, 4'd4, 32'd3, 1'b0, '0);
		send_word(CMD_RESTART, 4'd4, '0, 1'b0, '0);
		send_word(CMD_ADD, 4'd0, '0, 1'b0, '0);
		send_word(CMD_ADD, 4'd15, '1, 1'b0, '0);
		send_word(CMD_ADD, 4'd1, 32'd1, 1'b1, '0);
		send_word(CMD_ADD, 4'd2, 32'd2, 1'b0, '0);
		send_word(CMD_TICK, '0, '0, 1'b0, 32'd2);
		send_word(CMD_TICK, '0, '0, 1'b0, 32'd5);
		send_word(CMD_ADD, 4'd2, 32'd2, 1'b0, 32'd10);
		send_word(CMD_TICK, '0, '0, 1'b0, 32'd11);
		for (k = CMD_REMOVE + 1; k < (1 << CMD_W); k++) begin
			send_word(k[CMD_W-1:0], '1, '1, 1'b1, '1);
		end
		send_word(CMD_ADD, 4'd7, 32'd5, 1'b1, 32'hFFFF_FFF0);
		send_word(CMD_TICK, '1, '1, 1'b1, 32'h0000_0010);
		send_word(CMD_SET_PERIOD, 4'd2, '0, 1'b0, 32'h0000_0020);
		send_word(CMD_RESTART, 4'd15, '0, 1'b0, '0);
		send_word(CMD_TICK, '0, '0, 1'b0, '1);
		send_word(CMD_REMOVE, 4'd15, '0, 1'b0, '0);
		send_word(CMD_REMOVE, 4'd2, '0, 1'b0, '0);

		// Random: mostly arm-then-tick sequences on a running time count,
		// the rest raw noise on every field and code.
		while (counted < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 7) == 0) begin
					t_now = '1 - $urandom_range(0, 40);
				end
				if ($urandom_range(0, 3) == 0) begin
					// arm every slot so one tick can expire all of them
					for (k = 0; k < MAX_SLOTS; k++) begin
						send_word(CMD_ADD, k[CH_W-1:0], $urandom_range(0, 3),
							1'($urandom_range(0, 1)), t_now);
					end
				end else begin
					repeat ($urandom_range(1, 5)) begin
						send_word(CMD_ADD, CH_W'($urandom_range(0, 15)), pick_period(),
							1'($urandom_range(0, 1)), t_now);
					end
				end
				steps = $urandom_range(2, 8);
				repeat (steps) begin
					t_now = t_now + $urandom_range(0, 6);
					case ($urandom_range(0, 5))
						0: send_word(CMD_RESTART, CH_W'($urandom_range(0, 15)), $urandom(),
							1'($urandom_range(0, 1)), t_now);
						1: send_word(CMD_SET_PERIOD, CH_W'($urandom_range(0, 15)),
							pick_period(), 1'($urandom_range(0, 1)), t_now);
						2: send_word(CMD_REMOVE, CH_W'($urandom_range(0, 15)), $urandom(),
							1'($urandom_range(0, 1)), t_now);
						default: ;
					endcase
					send_word(CMD_TICK, CH_W'($urandom_range(0, 15)), $urandom(),
						1'($urandom_range(0, 1)), t_now);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_word(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)),
						CH_W'($urandom_range(0, 15)), $urandom(),
						1'($urandom_range(0, 1)), $urandom());
				end
			end
		end
		s_tvalid <= 1'b0;

		// Let the checker see the last push, then drain.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
